// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level of the sobel edge block
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define SEM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sobel edge assertion failed");
// checked at every edge, reset included
`define SEM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sobel edge assertion failed");
`else
`define SEM_ASSERT(lbl, clk, rst, prop)
`define SEM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/sem_pkg.sv =====
// shared types and constants of the sobel edge magnitude block
// no dependencies; imported by sem_isqrt and the top level
package sem_pkg;

  localparam int PIX_W      = 8;   // pixel and magnitude width
  localparam int COL_OUT_W  = 10;  // out_col width
  localparam int ROW_W      = 12;  // row counter and out_row width
  localparam int IW_W       = 11;  // image_width register width
  localparam int IH_W       = 13;  // image_height register width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 10;  // one side of a kernel sum, up to 4*255
  localparam int GRAD_W     = 11;  // signed gradient
  localparam int SQ_W       = 21;  // gx^2 + gy^2
  localparam int ROOT_IN_W  = 16;  // radicand bits handled by the root unit

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IW_W-1:0]      IW_RESET      = 11'd640;
  localparam logic [IH_W-1:0]      IH_RESET      = 13'd480;
  localparam int                   MIN_DIM       = 3;
  localparam logic [IH_W-1:0]      MAX_HEIGHT    = 13'd4096;
  localparam logic [PIX_W-1:0]     MAG_MAX       = 8'hff;
  localparam logic [ROOT_IN_W-1:0] ROOT_BIT_INIT = 16'h4000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_HOLD
  } sem_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

// ===== rtl/sem_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle, saturating at 255
// depends on sem_pkg
module sem_isqrt import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output sqrt_status_t     stat,
  output logic [PIX_W-1:0] root_out
);

  logic                 busy;
  logic                 done;
  logic                 sat;
  logic [ROOT_IN_W-1:0] rem;
  logic [ROOT_IN_W-1:0] root;
  logic [ROOT_IN_W-1:0] bitr;
  logic [ROOT_IN_W:0]   trial;
  logic                 fits;
  logic                 last;

  assign trial = {1'b0, root} + {1'b0, bitr};
  assign fits  = {1'b0, rem} >= trial;
  assign last  = bitr == ROOT_IN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand[ROOT_IN_W-1:0];
      sat  <= |radicand[SQ_W-1:ROOT_IN_W];
      root <= '0;
      bitr <= ROOT_BIT_INIT;
    end else if (busy) begin
      if (fits) begin
        rem  <= rem - trial[ROOT_IN_W-1:0];
        root <= (root >> 1) + bitr;
      end else begin
        root <= root >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  // radicand of 65536 or more has a root of at least 256
  assign root_out  = sat ? MAG_MAX : root[PIX_W-1:0];

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// top level of the streaming 3x3 sobel edge magnitude block
// depends on sem_pkg, sem_isqrt and assert_macros.svh
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   in      | in_valid / in_stall       | pixel
//   out     | out_valid / out_stall     | magnitude, out_col, out_row, frame_last
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one pixel at a time: a pixel at row >= 2 and column >= 2 goes through the line store
// read, the square and eight steps of the shared root unit before the next pixel
// is accepted; a border pixel goes only through the line store read
// the output register lets the next pixel in while a result waits on out_stall
// synchronous reset clears counters, window and control; line store contents
// stay undefined until written, and there is no clearing pass
`include "assert_macros.svh"

module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      magnitude,
  output logic [COL_OUT_W-1:0]  out_col,
  output logic [ROW_W-1:0]      out_row,
  output logic                  frame_last,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // column counter addresses the line store directly
  localparam int CW  = $clog2(MAX_WIDTH);
  // width that holds both the width register and MAX_WIDTH itself
  localparam int EW  = ($clog2(MAX_WIDTH + 1) > IW_W) ? $clog2(MAX_WIDTH + 1) : IW_W;
  localparam int XW  = (CW > COL_OUT_W) ? CW : COL_OUT_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

  sem_state_t state, state_next;

  // size registers and their clamped values
  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;
  logic [EW-1:0]   eff_w;
  logic [IH_W-1:0] eff_h;

  // position of the pixel now in flight
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             col_last;
  logic             row_last;
  logic             emit_now;
  logic [XW-1:0]    col_dec;

  // line store: {two rows up, one row up} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] lb_q;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;

  // window columns c-2 (0..2) and c-1 (3..5), top to bottom
  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] pix_r;

  logic [SUM_W-1:0]            gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0]    gx_d, gy_d, gx, gy;
  logic signed [2*GRAD_W-1:0]  gx_sq, gy_sq;
  logic [SQ_W-1:0]             radicand;

  // pending result position
  logic [COL_OUT_W-1:0] res_col;
  logic [ROW_W-1:0]     res_row;
  logic                 res_last;

  sqrt_status_t     sq_stat;
  logic [PIX_W-1:0] root_mag;

  logic cfg_fire;
  logic in_fire;
  logic mem_we;
  logic sqrt_start;
  logic out_free;
  logic out_load;

  // clamp sizes to the supported range
  always_comb begin
    eff_w = EW'(image_width);
    if (eff_w < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (eff_w > MAX_W_E) begin
      eff_w = MAX_W_E;
    end
    eff_h = image_height;
    if (eff_h < IH_W'(MIN_DIM)) begin
      eff_h = IH_W'(MIN_DIM);
    end else if (eff_h > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end
  end

  assign col_last = (EW'(col) + EW'(1)) >= eff_w;
  assign row_last = (IH_W'(row) + IH_W'(1)) >= eff_h;
  assign emit_now = (row >= ROW_W'(2)) && (col >= CW'(2));
  assign col_dec  = XW'(col) - XW'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = emit_now ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    out_free   = !out_valid || !out_stall;
    cfg_ready  = state == ST_IDLE;
    // a register write wins over a pixel offered in the same cycle
    in_stall   = !(state == ST_IDLE && !cfg_valid);
    mem_we     = state == ST_READ;
    sqrt_start = state == ST_SQUARE;
    out_load   = ((state == ST_ROOT && sq_stat.done) || state == ST_HOLD) && out_free;
  end

  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line store: read every cycle at the current column, written back after use
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col] <= {mid, pix_r};
    end
    lb_q <= line_mem[col];
  end

  assign top = lb_q[2*PIX_W-1:PIX_W];
  assign mid = lb_q[PIX_W-1:0];

  // registers, counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IW_RESET;
      image_height <= IH_RESET;
      col          <= '0;
      row          <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[IW_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
        end
        default: begin
        end
      endcase
      // any known register write restarts the frame
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
        col <= '0;
        row <= '0;
        for (int i = 0; i < 6; i++) begin
          win[i] <= '0;
        end
      end
    end else if (state == ST_READ) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= pix_r;
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // kernel sums of the 3x3 window
  always_comb begin
    gx_pos = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(pix_r);
    gx_neg = SUM_W'(win[0]) + (SUM_W'(win[1]) << 1) + SUM_W'(win[2]);
    gy_pos = SUM_W'(win[2]) + (SUM_W'(win[5]) << 1) + SUM_W'(pix_r);
    gy_neg = SUM_W'(win[0]) + (SUM_W'(win[3]) << 1) + SUM_W'(top);
    gx_d   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy_d   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  assign gx_sq    = gx * gx;
  assign gy_sq    = gy * gy;
  // both squares are non-negative and their sum stays below 2^21
  assign radicand = gx_sq[SQ_W-1:0] + gy_sq[SQ_W-1:0];

  // payload registers of the item in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r <= pixel;
    end
    if (state == ST_READ) begin
      gx       <= gx_d;
      gy       <= gy_d;
      res_col  <= col_dec[COL_OUT_W-1:0];
      res_row  <= row - ROW_W'(1);
      res_last <= col_last && row_last;
    end
  end

  sem_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .stat     (sq_stat),
    .root_out (root_mag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      magnitude  <= root_mag;
      out_col    <= res_col;
      out_row    <= res_row;
      frame_last <= res_last;
    end
  end

  // an accepted pixel always goes to the line store read step next
  `SEM_ASSERT(a_accept_reads, clk, rst, in_fire |=> state == ST_READ)
  // the root unit only finishes while the sequencer waits for it
  `SEM_ASSERT(a_root_done_state, clk, rst, sq_stat.done |-> state == ST_ROOT)
  // position counters stay inside the clamped frame
  `SEM_ASSERT(a_col_in_frame, clk, rst, EW'(col) < eff_w)
  `SEM_ASSERT(a_row_in_frame, clk, rst, IH_W'(row) < eff_h)
  // a new result only comes from a finished root
  `SEM_ASSERT(a_out_from_root, clk, rst,
    $rose(out_valid) |-> ($past(state) == ST_ROOT || $past(state) == ST_HOLD))
  `SEM_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid && state == ST_IDLE)

endmodule
